### hdl/hex_line_orientation_filter_defines.svh
// assertion macros for the hexagonal line orientation filter
`ifndef HEX_LINE_ORIENTATION_FILTER_DEFINES_SVH
`define HEX_LINE_ORIENTATION_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define HLOF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
        else $error("hlof: invariant violated");

// consequence holds in the same cycle as the antecedent
`define HLOF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlof: same-cycle implication violated");

// consequence holds in the cycle after the antecedent
`define HLOF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlof: next-cycle implication violated");

`else

`define HLOF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define HLOF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HLOF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/hlof_pkg.sv
// shared types and constants of the line orientation filter
package hlof_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int LINE_BITS      = SAMPLE_BITS + 1;
    localparam int POS_BITS       = 10;
    localparam int MAX_HEIGHT     = 1024;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * LINE_BITS + 2 * POS_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [LINE_BITS-1:0]    line_t;
    typedef logic [POS_BITS-1:0]     pos_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_HEX_MODE     = 2'd0;
    localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd2;

    // neighborhood of one pixel as handed to the response pipeline
    typedef struct packed {
        sample_t c;
        sample_t nx;
        sample_t x;
        sample_t ny;
        sample_t y;
        sample_t nz;
        sample_t z;
        logic    hex;
        pos_t    row;
        pos_t    col;
    } hlof_tap_t;

    // one finished result item
    typedef struct packed {
        line_t line_x;
        line_t line_y;
        line_t line_z;
        pos_t  out_row;
        pos_t  out_col;
    } hlof_res_t;

endpackage

### hdl/hlof_line_cell.sv
// one row cell: two-tap pixel window plus a one-row delay in block memory
module hlof_line_cell
    import hlof_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int DATA_W    = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clr,
    input  logic                         adv,
    input  logic [$clog2(MAX_WIDTH)-1:0] width_last,
    input  logic                         width_one,
    input  logic [DATA_W-1:0]            din,
    output logic [DATA_W-1:0]            tap1,
    output logic [DATA_W-1:0]            tap2,
    output logic [DATA_W-1:0]            dout
);

    localparam int PTR_W = $clog2(MAX_WIDTH);

    logic [DATA_W-1:0] line_mem [MAX_WIDTH];
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [DATA_W-1:0] tap1_reg;
    logic [DATA_W-1:0] tap2_reg;
    logic [DATA_W-1:0] dout_reg;

    // slot pointer wraps once per row
    always_comb
    begin
        if (ptr_reg == width_last)
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (clr)
        begin
            ptr_reg <= '0;
        end
        else if (adv)
        begin
            ptr_reg <= ptr_next;
        end
    end

    // row delay: read ahead the slot written one row back, bypass for one-pixel rows
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_mem[ptr_reg] <= din;
            if (width_one)
            begin
                dout_reg <= din;
            end
            else
            begin
                dout_reg <= line_mem[ptr_next];
            end
        end
    end

    // pixel window
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tap1_reg <= din;
            tap2_reg <= tap1_reg;
        end
    end

    assign tap1 = tap1_reg;
    assign tap2 = tap2_reg;
    assign dout = dout_reg;

endmodule

### hdl/hlof_resp.sv
// response pipeline: pair sums, weighted terms, clamped difference
module hlof_resp
    import hlof_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tap_valid,
    input  hlof_tap_t tap,
    output logic      res_valid,
    output hlof_res_t res
);

    localparam int SUM_W  = SAMPLE_BITS + 1;
    localparam int TERM_W = SAMPLE_BITS + 2;

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    hlof_tap_t         tap_reg;

    logic [SUM_W-1:0]  sx2_reg;
    logic [SUM_W-1:0]  sy2_reg;
    logic [SUM_W-1:0]  sz2_reg;
    sample_t           c2_reg;
    logic              hex2_reg;
    pos_t              row2_reg;
    pos_t              col2_reg;

    logic [TERM_W-1:0] posx3_reg;
    logic [TERM_W-1:0] negx3_reg;
    logic [TERM_W-1:0] posy3_reg;
    logic [TERM_W-1:0] negy3_reg;
    logic [TERM_W-1:0] posz3_reg;
    logic [TERM_W-1:0] negz3_reg;
    logic              hex3_reg;
    pos_t              row3_reg;
    pos_t              col3_reg;

    hlof_res_t         res_reg;

    logic [TERM_W-1:0] qx;
    logic [TERM_W-1:0] qy;
    logic [TERM_W-1:0] qz;
    logic [TERM_W-1:0] hx;
    logic [TERM_W-1:0] hy;
    logic [TERM_W-1:0] hz;
    logic [TERM_W-1:0] cw;
    line_t             lx;
    line_t             ly;
    line_t             lz;

    // valid bits move every cycle, the output buffer absorbs stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= tap_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: capture the neighborhood
    always_ff @(posedge clk)
    begin
        tap_reg <= tap;
    end

    // stage 2: axis pair sums
    always_ff @(posedge clk)
    begin
        sx2_reg  <= {1'b0, tap_reg.nx} + {1'b0, tap_reg.x};
        sy2_reg  <= {1'b0, tap_reg.ny} + {1'b0, tap_reg.y};
        sz2_reg  <= {1'b0, tap_reg.nz} + {1'b0, tap_reg.z};
        c2_reg   <= tap_reg.c;
        hex2_reg <= tap_reg.hex;
        row2_reg <= tap_reg.row;
        col2_reg <= tap_reg.col;
    end

    // quarters of the other two pairs, halves of each pair
    always_comb
    begin
        qx = ({1'b0, sy2_reg} + {1'b0, sz2_reg}) >> 2;
        qy = ({1'b0, sx2_reg} + {1'b0, sz2_reg}) >> 2;
        qz = ({1'b0, sx2_reg} + {1'b0, sy2_reg}) >> 2;
        hx = {1'b0, sx2_reg} >> 1;
        hy = {1'b0, sy2_reg} >> 1;
        hz = {1'b0, sz2_reg} >> 1;
        cw = {2'b00, c2_reg};
    end

    // stage 3: positive and negative terms per axis
    always_ff @(posedge clk)
    begin
        if (hex2_reg)
        begin
            posx3_reg <= cw + qx;
            negx3_reg <= hx;
            posy3_reg <= cw + qy;
            negy3_reg <= hy;
        end
        else
        begin
            posx3_reg <= cw + hy;
            negx3_reg <= {1'b0, sx2_reg};
            posy3_reg <= cw + hx;
            negy3_reg <= {1'b0, sy2_reg};
        end
        posz3_reg <= cw + qz;
        negz3_reg <= hz;
        hex3_reg  <= hex2_reg;
        row3_reg  <= row2_reg;
        col3_reg  <= col2_reg;
    end

    // clamp at zero; line_z stays zero outside hex mode
    always_comb
    begin
        lx = (posx3_reg > negx3_reg) ? LINE_BITS'(posx3_reg - negx3_reg) : '0;
        ly = (posy3_reg > negy3_reg) ? LINE_BITS'(posy3_reg - negy3_reg) : '0;
        lz = (hex3_reg && (posz3_reg > negz3_reg)) ? LINE_BITS'(posz3_reg - negz3_reg) : '0;
    end

    // stage 4: result register
    always_ff @(posedge clk)
    begin
        res_reg.line_x  <= lx;
        res_reg.line_y  <= ly;
        res_reg.line_z  <= lz;
        res_reg.out_row <= row3_reg;
        res_reg.out_col <= col3_reg;
    end

    assign res_valid = v4_reg;
    assign res       = res_reg;

endmodule

### hdl/hlof_out_fifo.sv
// small result buffer between the response pipeline and the output stream
module hlof_out_fifo
    import hlof_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hlof_res_t push_data,
    input  logic      pop,
    output logic      not_empty,
    output hlof_res_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hlof_res_t        fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign pop_data  = fifo_mem[rd_ptr_reg];

endmodule

### hdl/hex_line_orientation_filter.sv
// top level of the hexagonal / square line orientation filter
//
// Takes one pixel item per clock in raster order and sustains one item per clock while
// input ready is high. The result for a pixel is computed once the pixel frame_width+1
// places later is accepted and leaves through an eight-item output buffer; the first
// frame_width+1 results of a frame are zero and the last frame_width+1 pixels of a
// frame give no result. The neighborhood comes from a chain of two row cells, each a
// one-row delay in a block memory of MAX_WIDTH entries with a two-pixel window, so a
// pixel costs one write and one read per memory. Input ready drops only while eight
// results are in flight or waiting. The line memories need no clearing pass after
// reset; a mode, width or height write restarts the frame at row zero, column zero.
`include "hex_line_orientation_filter_defines.svh"

module hex_line_orientation_filter
    import hlof_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // pixel items in
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // edge_on, edge_off
    // result items out
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata    // line_x, line_y, line_z, out_row, out_col, pad
);

    localparam int PTR_W      = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int PIX_W      = PTR_W + POS_BITS;
    localparam int FIFO_DEPTH = 8;
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
    localparam int PAIR_W     = 2 * SAMPLE_BITS;

    // configuration registers
    logic                     hex_mode_reg;
    logic [CFG_DATA_BITS-1:0] frame_width_reg;
    logic [CFG_DATA_BITS-1:0] frame_height_reg;
    logic                     cfg_clear;

    // effective frame size
    logic [WW-1:0]            eff_w;
    logic [CFG_DATA_BITS-1:0] eff_h;
    logic [PTR_W-1:0]         w_last;
    logic                     w_one;
    pos_t                     h_last;

    // positions
    logic [PTR_W-1:0]         col_reg;
    logic [PTR_W-1:0]         col_next;
    pos_t                     row_reg;
    pos_t                     row_next;
    logic [PIX_W-1:0]         pix_reg;
    logic [PIX_W-1:0]         pix_next;
    logic [PTR_W-1:0]         ocol_reg;
    logic [PTR_W-1:0]         ocol_next;
    pos_t                     orow_reg;
    pos_t                     orow_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    logic                     s_accept;
    logic                     m_accept;
    logic                     send;
    logic                     interior;
    logic                     frame_end;

    // neighborhood taps
    sample_t                  on_in;
    sample_t                  off_in;
    logic [PAIR_W-1:0]        c0_tap1;
    logic [PAIR_W-1:0]        c0_tap2;
    logic [PAIR_W-1:0]        c0_dout;
    sample_t                  c1_tap1;
    sample_t                  c1_tap2;
    sample_t                  c1_dout;
    sample_t                  r1_reg;
    sample_t                  r2_reg;
    sample_t                  on_d_reg;
    hlof_tap_t                tap;

    logic                     res_valid;
    hlof_res_t                res;
    hlof_res_t                out_res;

    assign on_in    = s_tdata[SAMPLE_BITS-1:0];
    assign off_in   = s_tdata[PAIR_W-1:SAMPLE_BITS];
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign cfg_clear = cfg_we && (cfg_index == CFG_HEX_MODE || cfg_index == CFG_FRAME_WIDTH ||
                                  cfg_index == CFG_FRAME_HEIGHT);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_mode_reg     <= 1'b1;
            frame_width_reg  <= CFG_DATA_BITS'(64);
            frame_height_reg <= CFG_DATA_BITS'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEX_MODE:     hex_mode_reg     <= cfg_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp frame size into range
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            eff_h = CFG_DATA_BITS'(1);
        end
        else if (32'(frame_height_reg) > MAX_HEIGHT)
        begin
            eff_h = CFG_DATA_BITS'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
        w_last = PTR_W'(eff_w - 1'b1);
        w_one  = (eff_w == WW'(1));
        h_last = POS_BITS'(eff_h - 1'b1);
    end

    // border classification of the pixel whose result this item releases
    assign send      = (pix_reg >= PIX_W'(eff_w) + PIX_W'(1));
    assign interior  = (pix_reg >= (PIX_W'(eff_w) << 1) + PIX_W'(2));
    assign frame_end = (col_reg == w_last) && (row_reg == h_last);

    // raster and result position counters
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pix_next  = pix_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (cfg_clear)
        begin
            col_next  = '0;
            row_next  = '0;
            pix_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (s_accept)
        begin
            if (frame_end)
            begin
                col_next  = '0;
                row_next  = '0;
                pix_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end
            else
            begin
                pix_next = pix_reg + 1'b1;
                if (col_reg == w_last)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                if (send)
                begin
                    if (ocol_reg == w_last)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + 1'b1;
                    end
                    else
                    begin
                        ocol_next = ocol_reg + 1'b1;
                    end
                end
            end
        end
    end

    // items in the response pipeline and the output buffer
    always_comb
    begin
        occ_next = occ_reg;
        if ((s_accept && send) && !m_accept)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (m_accept && !(s_accept && send))
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pix_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pix_reg  <= pix_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            occ_reg  <= occ_next;
        end
    end

    assign s_tready = (32'(occ_reg) < FIFO_DEPTH);

    // first row cell: current row, carries ON beside OFF
    hlof_line_cell #(
        .MAX_WIDTH (MAX_WIDTH),
        .DATA_W    (PAIR_W)
    ) u_cell0 (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (cfg_clear),
        .adv        (s_accept),
        .width_last (w_last),
        .width_one  (w_one),
        .din        ({on_in, off_in}),
        .tap1       (c0_tap1),
        .tap2       (c0_tap2),
        .dout       (c0_dout)
    );

    // second row cell: one row back, OFF only
    hlof_line_cell #(
        .MAX_WIDTH (MAX_WIDTH),
        .DATA_W    (SAMPLE_BITS)
    ) u_cell1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (cfg_clear),
        .adv        (s_accept),
        .width_last (w_last),
        .width_one  (w_one),
        .din        (c0_dout[SAMPLE_BITS-1:0]),
        .tap1       (c1_tap1),
        .tap2       (c1_tap2),
        .dout       (c1_dout)
    );

    // window of the row two back, and the centre ON value
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            r1_reg   <= c1_dout;
            r2_reg   <= r1_reg;
            on_d_reg <= c0_dout[PAIR_W-1:SAMPLE_BITS];
        end
    end

    // pick axis pairs by mode and row parity; border pixels get zero taps
    always_comb
    begin
        tap     = '0;
        tap.hex = hex_mode_reg;
        tap.row = orow_reg;
        tap.col = POS_BITS'(ocol_reg);
        if (interior)
        begin
            tap.c  = on_d_reg;
            tap.ny = c1_tap2;
            tap.y  = c0_dout[SAMPLE_BITS-1:0];
            if (!hex_mode_reg)
            begin
                tap.nx = r1_reg;
                tap.x  = c0_tap1[SAMPLE_BITS-1:0];
            end
            else if (orow_reg[0])
            begin
                tap.nx = r1_reg;
                tap.x  = off_in;
                tap.nz = c0_tap1[SAMPLE_BITS-1:0];
                tap.z  = c1_dout;
            end
            else
            begin
                tap.nx = r2_reg;
                tap.x  = c0_tap1[SAMPLE_BITS-1:0];
                tap.nz = c0_tap2[SAMPLE_BITS-1:0];
                tap.z  = r1_reg;
            end
        end
    end

    // response pipeline
    hlof_resp u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (s_accept && send),
        .tap       (tap),
        .res_valid (res_valid),
        .res       (res)
    );

    hlof_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_accept),
        .not_empty (m_tvalid),
        .pop_data  (out_res)
    );

    assign m_tdata = {{OUT_PAD_BITS{1'b0}}, out_res.out_col, out_res.out_row,
                      out_res.line_z, out_res.line_y, out_res.line_x};

    // checks
    `HLOF_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, 32'(occ_reg) <= FIFO_DEPTH)
    `HLOF_ASSERT_IMPLY(a_out_counted, clk, rst_n, m_tvalid, occ_reg != '0)
    `HLOF_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_clear, (pix_reg == '0) && (ocol_reg == '0) && (orow_reg == '0))
    `HLOF_ASSERT_ALWAYS(a_col_in_row, clk, rst_n, 32'(col_reg) < 32'(eff_w))

endmodule

### sim/tb.sv
// testbench for the hexagonal / square line orientation filter
`timescale 1ns / 1ps

module tb;
    import hlof_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int OFF_SLOTS  = 2 * MAX_W + 2;
    localparam int ON_SLOTS   = MAX_W + 1;
    localparam int LAT_PAUSE  = 16;
    localparam int RAND_ITEMS = 300;

    // index with no register behind it
    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata;   // edge_on, edge_off
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;   // line_x, line_y, line_z, out_row, out_col, pad

    hex_line_orientation_filter #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // directed stimulus row: either a register write or one pixel item
    typedef struct {
        bit                       is_cfg;
        cfg_idx_t                 idx;
        logic [CFG_DATA_BITS-1:0] val;
        sample_t                  on_v;
        sample_t                  off_v;
        bit                       known;
        hlof_res_t                want;
    } stim_row_t;

    stim_row_t   stim_table[$];
    hlof_res_t   pending_lines[$];

    // predictor state
    sample_t                  off_hist[OFF_SLOTS];
    sample_t                  on_hist[ON_SLOTS];
    int unsigned              off_wp;
    int unsigned              on_wp;
    int unsigned              pix_col;
    int unsigned              pix_row;
    bit                       mode_hex;
    logic [CFG_DATA_BITS-1:0] reg_w;
    logic [CFG_DATA_BITS-1:0] reg_h;

    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned settings_run;
    bit          paused_once;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(30_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (reg_w == 0) return 1;
        if (reg_w > MAX_W) return MAX_W;
        return reg_w;
    endfunction

    function automatic int unsigned eff_height();
        if (reg_h == 0) return 1;
        if (reg_h > MAX_HEIGHT) return MAX_HEIGHT;
        return reg_h;
    endfunction

    // off value of the pixel k places back, k = 0 being the incoming one
    function automatic longint off_tap(int unsigned k, sample_t cur);
        if (k == 0) return cur;
        return off_hist[(off_wp + OFF_SLOTS - k) % OFF_SLOTS];
    endfunction

    function automatic longint on_tap(int unsigned k);
        return on_hist[(on_wp + ON_SLOTS - k) % ON_SLOTS];
    endfunction

    function automatic line_t clamp_line(longint v);
        return (v < 0) ? line_t'(0) : line_t'(v);
    endfunction

    // oriented line responses of the pixel width+1 places back; advances the line stores
    function automatic bit line_response(sample_t on_v, sample_t off_v, output hlof_res_t res);
        int unsigned w, h, col, row, p, len, i, orow;
        longint      c, nx, x, ny, y, nz, z;
        bit          has;
        w   = eff_width();
        h   = eff_height();
        col = (pix_col < w) ? pix_col : w - 1;
        row = (pix_row < h) ? pix_row : h - 1;
        p   = row * w + col;
        len = w * h;
        res = '0;
        has = 1'b0;
        if (p >= w + 1)
        begin
            has  = 1'b1;
            i    = p - w - 1;
            orow = i / w;
            res.out_row = pos_t'(orow);
            res.out_col = pos_t'(i % w);
            // border pixels stay zero
            if (i >= w + 1 && i + w + 1 < len)
            begin
                c  = on_tap(w + 1);
                ny = off_tap(w + 2, off_v);
                y  = off_tap(w, off_v);
                if (mode_hex)
                begin
                    // neighbor offsets shift with row parity
                    if (orow[0])
                    begin
                        nx = off_tap(2 * w + 1, off_v);
                        x  = off_tap(0, off_v);
                        nz = off_tap(1, off_v);
                        z  = off_tap(2 * w, off_v);
                    end
                    else
                    begin
                        nx = off_tap(2 * w + 2, off_v);
                        x  = off_tap(1, off_v);
                        nz = off_tap(2, off_v);
                        z  = off_tap(2 * w + 1, off_v);
                    end
                    res.line_x = clamp_line(c - (nx + x) / 2 + (ny + y + nz + z) / 4);
                    res.line_y = clamp_line(c - (ny + y) / 2 + (nx + x + nz + z) / 4);
                    res.line_z = clamp_line(c - (nz + z) / 2 + (nx + x + ny + y) / 4);
                end
                else
                begin
                    nx = off_tap(2 * w + 1, off_v);
                    x  = off_tap(1, off_v);
                    res.line_x = clamp_line(c - (nx + x) + (ny + y) / 2);
                    res.line_y = clamp_line(c - (ny + y) + (nx + x) / 2);
                end
            end
        end
        // shift the new pixel into the stores
        off_hist[off_wp] = off_v;
        off_wp           = (off_wp + 1) % OFF_SLOTS;
        on_hist[on_wp]   = on_v;
        on_wp            = (on_wp + 1) % ON_SLOTS;
        // raster position of the next pixel
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        pix_col = col;
        pix_row = row;
        return has;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(0, 255));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int unsigned idle_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_cfg(cfg_idx_t idx, int unsigned val);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = CFG_DATA_BITS'(val);
        stim_table.push_back(row);
    endfunction

    function automatic void add_pixel(sample_t on_v, sample_t off_v);
        stim_row_t row;
        row       = '{default: '0};
        row.on_v  = on_v;
        row.off_v = off_v;
        stim_table.push_back(row);
    endfunction

    function automatic void add_known(sample_t on_v, sample_t off_v, line_t lx, line_t ly,
                                      line_t lz, pos_t r, pos_t c);
        stim_row_t row;
        row              = '{default: '0};
        row.on_v         = on_v;
        row.off_v        = off_v;
        row.known        = 1'b1;
        row.want.line_x  = lx;
        row.want.line_y  = ly;
        row.want.line_z  = lz;
        row.want.out_row = r;
        row.want.out_col = c;
        stim_table.push_back(row);
    endfunction

    function automatic void cmp_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // stop sending and wait for every outstanding result, then let the pipe empty
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge clk);
        repeat (LAT_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_HEX_MODE:     mode_hex = val[0];
            CFG_FRAME_WIDTH:  reg_w    = val;
            CFG_FRAME_HEIGHT: reg_h    = val;
            default:          ;
        endcase
        if (idx != CFG_UNUSED)
        begin
            pix_col = 0;
            pix_row = 0;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    // offer one pixel item and record what it should produce
    task automatic push_pixel(sample_t on_v, sample_t off_v, int unsigned gap, bit known,
                              hlof_res_t known_res);
        hlof_res_t want;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {off_v, on_v};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (line_response(on_v, off_v, want))
            pending_lines.push_back(known ? known_res : want);
        else if (known)
        begin
            $display("%0t: pixel item gave no result, expected row %0d col %0d",
                     $time, known_res.out_row, known_res.out_col);
            mismatches++;
        end
    endtask

    task automatic run_pixels(int unsigned n, bit calm);
        for (int unsigned k = 0; k < n; k++)
        begin
            // sender holds off until the block has caught up
            if ($urandom_range(0, 199) == 0 || (!paused_once && k == n / 2 && n > 8))
            begin
                settle_block();
                paused_once = 1'b1;
            end
            push_pixel(rand_sample(), rand_sample(), idle_gap(calm), 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        hlof_res_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.line_x  = m_tdata[0 +: LINE_BITS];
            got.line_y  = m_tdata[LINE_BITS +: LINE_BITS];
            got.line_z  = m_tdata[2 * LINE_BITS +: LINE_BITS];
            got.out_row = m_tdata[3 * LINE_BITS +: POS_BITS];
            got.out_col = m_tdata[3 * LINE_BITS + POS_BITS +: POS_BITS];
            results_seen++;
            if (pending_lines.size() == 0)
            begin
                $display("%0t: result item with nothing expected, row %0d col %0d",
                         $time, got.out_row, got.out_col);
                mismatches++;
            end
            else
            begin
                want = pending_lines.pop_front();
                cmp_field("line_x", want.line_x, got.line_x);
                cmp_field("line_y", want.line_y, got.line_y);
                cmp_field("line_z", want.line_z, got.line_z);
                cmp_field("out_row", want.out_row, got.out_row);
                cmp_field("out_col", want.out_col, got.out_col);
            end
        end
    end

    // receiver stalls: short and long ones, with calm stretches between
    initial
    begin : ready_gen
        int unsigned hold, r;
        m_tready = 1'b0;
        hold     = 0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(0, 3);
                end
                else if (r < 85)
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end
                else if (r < 95)
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(5, 30);
                end
                else
                begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(30, 120);
                end
            end
        end
    end

    // main sequence
    initial
    begin : main_seq
        int unsigned              rand_items, fsize, n, w_v, h_v, r;
        bit                       first;
        logic [CFG_DATA_BITS-1:0] cfg_word;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        // predictor after reset
        foreach (off_hist[k]) off_hist[k] = '0;
        foreach (on_hist[k]) on_hist[k] = '0;
        off_wp       = 0;
        on_wp        = 0;
        pix_col      = 0;
        pix_row      = 0;
        mode_hex     = 1'b1;
        reg_w        = 64;
        reg_h        = 64;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        settings_run = 0;
        paused_once  = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // first pass runs on the reset configuration
        run_pixels(40, 1'b0);

        // hex 2x4 frame, full on and no off: borders zero, interior saturates at on
        add_cfg(CFG_HEX_MODE, 1);
        add_cfg(CFG_FRAME_WIDTH, 2);
        add_cfg(CFG_FRAME_HEIGHT, 4);
        add_pixel(16'hFFFF, 16'h0000);
        add_pixel(16'hFFFF, 16'h0000);
        add_pixel(16'hFFFF, 16'h0000);
        add_known(16'hFFFF, 16'h0000, 0, 0, 0, 0, 0);
        add_known(16'hFFFF, 16'h0000, 0, 0, 0, 0, 1);
        add_known(16'hFFFF, 16'h0000, 0, 0, 0, 1, 0);
        add_known(16'hFFFF, 16'h0000, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 1, 1);
        add_known(16'hFFFF, 16'h0000, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 2, 0);
        // square 2x4 frame, no on and full off: everything clamps to zero
        add_cfg(CFG_HEX_MODE, 0);
        add_pixel(16'h0000, 16'hFFFF);
        add_pixel(16'h0000, 16'hFFFF);
        add_pixel(16'h0000, 16'hFFFF);
        add_known(16'h0000, 16'hFFFF, 0, 0, 0, 0, 0);
        add_known(16'h0000, 16'hFFFF, 0, 0, 0, 0, 1);
        add_known(16'h0000, 16'hFFFF, 0, 0, 0, 1, 0);
        add_known(16'h0000, 16'hFFFF, 0, 0, 0, 1, 1);
        add_known(16'h0000, 16'hFFFF, 0, 0, 0, 2, 0);
        // one-pixel-wide hex column, neighbors wrap through adjacent rows
        add_cfg(CFG_HEX_MODE, 1);
        add_cfg(CFG_FRAME_WIDTH, 1);
        add_cfg(CFG_FRAME_HEIGHT, 5);
        add_pixel(16'h1234, 16'hFFFF);
        add_pixel(16'hFFFF, 16'h0001);
        add_known(16'hFFFF, 16'h8000, 0, 0, 0, 0, 0);
        add_known(16'h00FF, 16'h7FFF, 0, 0, 0, 1, 0);
        add_pixel(16'hA5A5, 16'h5A5A);
        // zero width and height act as one: a single-pixel frame sends nothing
        add_cfg(CFG_FRAME_WIDTH, 0);
        add_cfg(CFG_FRAME_HEIGHT, 0);
        add_pixel(16'hFFFF, 16'hFFFF);
        add_pixel(16'h0001, 16'h0001);
        // oversize width and height clamp
        add_cfg(CFG_FRAME_WIDTH, 2047);
        add_cfg(CFG_FRAME_HEIGHT, 2047);
        add_pixel(16'h8000, 16'h8000);
        add_pixel(16'h7FFF, 16'h7FFF);

        foreach (stim_table[k])
        begin
            if (stim_table[k].is_cfg)
                write_reg(stim_table[k].idx, stim_table[k].val);
            else
                push_pixel(stim_table[k].on_v, stim_table[k].off_v, idle_gap(1'b0),
                           stim_table[k].known, stim_table[k].want);
        end

        // random settings, mostly small frames run whole with some partial tails
        rand_items = 0;
        first      = 1'b1;
        while (rand_items < RAND_ITEMS)
        begin
            r   = $urandom_range(0, 99);
            w_v = (r < 85) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 40) : 0;
            r   = $urandom_range(0, 99);
            h_v = (r < 80) ? $urandom_range(1, 8) : (r < 90) ? 0 : $urandom_range(1025, 2047);
            if (first || $urandom_range(0, 3) != 0)
            begin
                cfg_word    = CFG_DATA_BITS'($urandom);
                cfg_word[0] = 1'($urandom_range(0, 1));
                write_reg(CFG_HEX_MODE, cfg_word);
            end
            if (first || $urandom_range(0, 3) != 0)
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(w_v));
            if (first || $urandom_range(0, 3) != 0)
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h_v));
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
            first = 1'b0;
            fsize = eff_width() * eff_height();
            if (fsize > 64) fsize = 64;
            n = $urandom_range(1, 3) * fsize + $urandom_range(0, fsize);
            if (n > 200) n = 200;
            run_pixels(n, $urandom_range(0, 3) == 0);
            rand_items += n;
        end

        // widest row: width clamps to the line store size
        write_reg(CFG_FRAME_WIDTH, 2047);
        write_reg(CFG_FRAME_HEIGHT, 2);
        run_pixels(1030, 1'b0);
        // tallest frame: height clamps and the frame wraps back to row zero
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 2047);
        run_pixels(1030, 1'b0);

        settle_block();
        $display("covered %0d pixel items and %0d result items over %0d register writes,",
                 items_sent, results_seen, settings_run);
        $display("hex and square grids, borders, clamping and out-of-range frame sizes");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
